### rtl/core/bounded_array_list_engine_assert.svh
// assertion macros for the bounded array list engine
`ifndef BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH

// same-cycle implication under reset
`define BALE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define BALE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bale_pkg.sv
// shared constants for the bounded array list engine
`default_nettype none

package bale_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_INS_FRONT = 3'd1;
    localparam logic [2:0] OP_INS_SORT  = 3'd2;
    localparam logic [2:0] OP_SEARCH    = 3'd3;
    localparam logic [2:0] OP_DEL_BACK  = 3'd4;
    localparam logic [2:0] OP_DEL_FRONT = 3'd5;
    localparam logic [2:0] OP_DEL_VALUE = 3'd6;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

endpackage

`default_nettype wire

### rtl/core/bounded_array_list_engine.sv
// bounded array list engine: ordered list of signed words with a sequenced memory
//
//  channel | signals                                      | dir
//  --------+----------------------------------------------+----
//  in      | in_valid, in_stall, opcode, value            | in
//  out     | out_valid, out_stall, status, found,         | out
//          | stored_count, is_empty, is_full              |
//
// one item at a time: the accept state, then a read state and a compare or write state
// for each element scanned or moved, then a finish state that presents the result
// reset clears the count and the handshake state; the memory needs no clearing
// a stalled result holds the finish cycle; a new item can be taken while one waits
`default_nettype none

`include "bounded_array_list_engine_assert.svh"

module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int IDX_W    = $clog2(CAPACITY)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [2:0]               opcode,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [CNT_W-1:0]              stored_count,
    output logic                          is_empty,
    output logic                          is_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    state_t                    state_reg, state_next;
    logic [2:0]                op_reg, op_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]          ptr_reg, ptr_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [1:0]                st_reg, st_next;
    logic                      hit_reg, hit_next;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg, status_next;
    logic                      found_reg, found_next;
    logic [CNT_W-1:0]          cnt_out_reg, cnt_out_next;
    logic                      empty_reg, empty_next;
    logic                      full_reg, full_next;

    logic [DATA_W-1:0]         mem [CAPACITY];
    logic [DATA_W-1:0]         rdata_reg;
    logic                      rd_en, wr_en;
    logic [IDX_W-1:0]          rd_addr, wr_addr;
    logic [DATA_W-1:0]         wr_data;

    logic                      accept;
    logic                      cmp_lt, cmp_eq;
    logic [CNT_W-1:0]          ptr_inc, ptr_dec;

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign stored_count = cnt_out_reg;
    assign is_empty     = empty_reg;
    assign is_full      = full_reg;

    // shared compare unit
    assign cmp_lt  = $signed(rdata_reg) < val_reg;
    assign cmp_eq  = rdata_reg == val_reg;
    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign ptr_dec = ptr_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        st_next        = st_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        cnt_out_next   = cnt_out_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = val_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    val_next   = value;
                    st_next    = ST_DONE;
                    hit_next   = 1'b0;
                    ptr_next   = '0;
                    pos_next   = '0;
                    state_next = S_FINISH;
                    unique case (opcode)
                        OP_APPEND:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                ptr_next   = count_reg;
                                state_next = S_UP_RD;
                            end
                        end
                        OP_INS_FRONT:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_UP_RD;
                            end
                        end
                        OP_INS_SORT:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_SEARCH:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        OP_DEL_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_DEL_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DN_RD;
                            end
                        end
                        OP_DEL_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    state_next = S_SCAN_CMP;
                end
                else if (op_reg == OP_INS_SORT)
                begin
                    pos_next   = ptr_reg;
                    ptr_next   = count_reg;
                    state_next = S_UP_RD;
                end
                else
                begin
                    st_next    = ST_MISS;
                    state_next = S_FINISH;
                end
            end

            S_SCAN_CMP:
            begin
                if (op_reg == OP_INS_SORT)
                begin
                    if (cmp_lt)
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        pos_next   = ptr_reg;
                        ptr_next   = count_reg;
                        state_next = S_UP_RD;
                    end
                end
                else if (cmp_eq)
                begin
                    hit_next   = 1'b1;
                    state_next = (op_reg == OP_DEL_VALUE) ? S_DN_RD : S_FINISH;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end

            S_UP_RD:
            begin
                if (ptr_reg > pos_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_dec[IDX_W-1:0];
                    state_next = S_UP_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[IDX_W-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_FINISH;
                end
            end

            S_UP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                wr_data    = rdata_reg;
                ptr_next   = ptr_dec;
                state_next = S_UP_RD;
            end

            S_DN_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc[IDX_W-1:0];
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
            end

            S_DN_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                wr_data    = rdata_reg;
                ptr_next   = ptr_inc;
                state_next = S_DN_RD;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    found_next     = hit_reg;
                    cnt_out_next   = count_reg;
                    empty_next     = (count_reg == '0);
                    full_next      = (count_reg == CAP_C);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            st_reg        <= ST_DONE;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            st_reg        <= st_next;
            hit_reg       <= hit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg   <= empty_next;
        full_reg    <= full_next;
    end

    // element memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    `BALE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_C,
        "count above capacity")
    `BALE_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != S_IDLE,
        "accept left engine idle")
    `BALE_ASSERT_IMPL(a_full_flag, clk, rst_n, out_valid && status == ST_FULL, is_full,
        "refused insert on non-full list")
    `BALE_ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid && status == ST_EMPTY, is_empty,
        "empty status on non-empty list")
    `BALE_ASSERT_IMPL(a_found_done, clk, rst_n, out_valid && found, status == ST_DONE,
        "found with error status")

endmodule

`default_nettype wire
